[rtl/cbmf_pkg.sv]
package cbmf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 12;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_WINDOW_RADIUS = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  localparam int RESET_WIDTH = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int RESET_RADIUS = 2;

  // per-lane control from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic acc_clr;
  } lane_ctl_t;

endpackage

[rtl/cbmf_lane.sv]
module cbmf_lane #(
  parameter int DEPTH = 1024,
  parameter int AW = 10,
  parameter int LW = 20
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  cbmf_pkg::lane_ctl_t                       ctl,
  input  logic [AW-1:0]                             wr_addr,
  input  logic [AW-1:0]                             rd_addr,
  input  logic signed [cbmf_pkg::SAMPLE_BITS-1:0]   wr_x,
  input  logic signed [cbmf_pkg::SAMPLE_BITS-1:0]   wr_y,
  output logic signed [LW-1:0]                      sum_x,
  output logic signed [LW-1:0]                      sum_y
);

  localparam int SB = cbmf_pkg::SAMPLE_BITS;

  logic [2*SB-1:0] mem [DEPTH];
  logic [2*SB-1:0] rd_data;
  logic            rd_valid;
  logic signed [SB-1:0] rd_x;
  logic signed [SB-1:0] rd_y;

  assign rd_x = rd_data[2*SB-1:SB];
  assign rd_y = rd_data[SB-1:0];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {wr_x, wr_y};
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= ctl.rd_en;
    end
  end

  // column sum of this ring row over the window
  always_ff @(posedge clk) begin
    if (ctl.acc_clr) begin
      sum_x <= '0;
      sum_y <= '0;
    end else if (rd_valid) begin
      sum_x <= sum_x + LW'(rd_x);
      sum_y <= sum_y + LW'(rd_y);
    end
  end

endmodule

[rtl/cbmf_merge.sv]
module cbmf_merge #(
  parameter int LANES = 10,
  parameter int LW = 20,
  parameter int SW = 24
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [LW-1:0] lane_x [LANES],
  input  logic signed [LW-1:0] lane_y [LANES],
  output logic signed [SW-1:0] sum_x,
  output logic signed [SW-1:0] sum_y
);

  logic signed [SW-1:0] acc_x;
  logic signed [SW-1:0] acc_y;

  always_comb begin
    acc_x = '0;
    acc_y = '0;
    for (int i = 0; i < LANES; i++) begin
      acc_x = acc_x + SW'(lane_x[i]);
      acc_y = acc_y + SW'(lane_y[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_x <= acc_x;
      sum_y <= acc_y;
    end
  end

endmodule

[rtl/cbmf_div.sv]
module cbmf_div #(
  parameter int NW = 24,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CNW = $clog2(NW + 1);

  logic [DW-1:0]  rem;
  logic [DW-1:0]  dvs;
  logic [CNW-1:0] cnt;
  logic           run;
  logic [DW:0]    rem_sh;
  logic           fits;

  assign rem_sh = {rem, quot[NW-1]};
  assign fits = rem_sh >= {1'b0, dvs};

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNW'(NW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      dvs  <= den;
    end else if (run) begin
      rem  <= fits ? DW'(rem_sh - {1'b0, dvs}) : rem_sh[DW-1:0];
      quot <= {quot[NW-2:0], fits};
    end
  end

endmodule

[rtl/clamped_box_mean_filter.sv]
// channel | direction | handshake         | payload
// in      | sink      | in_valid/in_stall   | opcode, frame_start, gx_sample, gy_sample
// out     | source    | out_valid/out_stall | gx_mean, gy_mean, frame_end
// cfg     | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one item at a time: an item with no result goes through check back to idle,
// an item with a result through check, a sweep of the clipped window columns
// read from the window's ring-row banks at once, flush, merge, divider start,
// the 24-bit divider that makes one bit a cycle, and done
// rst is synchronous; line store is never cleared, counters return to zero
// a finished result sits in the output register while the next item is taken
// out_stall adds cycles only when a new result finds that register still full

module clamped_box_mean_filter #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_RADIUS = 4
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  output logic                                              in_stall,
  input  logic                                              opcode,
  input  logic                                              frame_start,
  input  logic signed [cbmf_pkg::SAMPLE_BITS-1:0]           gx_sample,
  input  logic signed [cbmf_pkg::SAMPLE_BITS-1:0]           gy_sample,
  output logic                                              out_valid,
  input  logic                                              out_stall,
  output logic signed [cbmf_pkg::SAMPLE_BITS-1:0]           gx_mean,
  output logic signed [cbmf_pkg::SAMPLE_BITS-1:0]           gy_mean,
  output logic                                              frame_end,
  input  logic                                              cfg_valid,
  output logic                                              cfg_ready,
  input  logic [cbmf_pkg::CFG_INDEX_BITS-1:0]               cfg_index,
  input  logic [cbmf_pkg::CFG_DATA_BITS-1:0]                cfg_data
);

  localparam int SB = cbmf_pkg::SAMPLE_BITS;
  localparam int RING = 2 * MAX_RADIUS + 2;
  localparam int SLW = $clog2(RING);
  localparam int CLW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int HW = 12;
  localparam int SPAN = 2 * MAX_RADIUS + 1;
  localparam int RCW = $clog2(SPAN + 1);
  localparam int CW = 2 * RCW;
  localparam int LW = SB + RCW;
  localparam int SW = LW + SLW;
  localparam int PW = HW + WW + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CHECK = 8'b00000010,
    S_SWEEP = 8'b00000100,
    S_FLUSH = 8'b00001000,
    S_MERGE = 8'b00010000,
    S_DIVGO = 8'b00100000,
    S_DIVW  = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state, state_next;

  logic [10:0]    w_cfg;
  logic [11:0]    h_cfg;
  logic [2:0]     r_cfg;
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [RW-1:0]  r_eff;

  logic [HW-1:0]  in_row, out_row;
  logic [CLW-1:0] in_col, out_col;
  logic [SLW-1:0] in_slot, out_slot;
  logic [PW-1:0]  pending;

  logic [CLW-1:0] xx, x1;
  logic [RING-1:0] lane_mask;
  logic [CW-1:0]  cnt;
  logic           last_pix;

  logic           accept;
  logic           cfg_wr;
  logic           restart;
  logic           store;
  logic [HW-1:0]  row_c;
  logic [CLW-1:0] col_c;
  logic [SLW-1:0] slot_c;
  logic [PW-1:0]  pend_c;

  always_comb begin
    logic [31:0] w32, r32;
    w32 = 32'(w_cfg);
    r32 = 32'(r_cfg);
    if (w32 == 0) w_eff = WW'(1);
    else if (w32 > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(w32);
    h_eff = (h_cfg == '0) ? HW'(1) : h_cfg;
    r_eff = (r32 > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(r32);
  end

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready &&
                  (cfg_index == cbmf_pkg::REG_IMAGE_WIDTH ||
                   cfg_index == cbmf_pkg::REG_IMAGE_HEIGHT ||
                   cfg_index == cbmf_pkg::REG_WINDOW_RADIUS);

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign restart = (opcode == cbmf_pkg::OP_PIXEL) && frame_start;

  always_comb begin
    row_c  = restart ? '0 : in_row;
    col_c  = restart ? '0 : in_col;
    slot_c = restart ? '0 : in_slot;
    pend_c = restart ? '0 : pending;
    store  = accept && (opcode == cbmf_pkg::OP_PIXEL) && (row_c < h_eff) &&
             (32'(col_c) < 32'(w_eff));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_cfg <= 11'(cbmf_pkg::RESET_WIDTH);
      h_cfg <= 12'(cbmf_pkg::RESET_HEIGHT);
      r_cfg <= 3'(cbmf_pkg::RESET_RADIUS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cbmf_pkg::REG_IMAGE_WIDTH:   w_cfg <= cfg_data[10:0];
        cbmf_pkg::REG_IMAGE_HEIGHT:  h_cfg <= cfg_data[11:0];
        cbmf_pkg::REG_WINDOW_RADIUS: r_cfg <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // window geometry for the pending result
  logic [PW-1:0]  lag;
  logic           emit;
  logic [CLW-1:0] x0_w, x1_w;
  logic [RCW-1:0] rows_w, cols_w;
  logic [RING-1:0] mask_w;

  always_comb begin
    logic [HW:0]  y0, y1, oy_r;
    logic [WW:0]  xa, xb;
    logic [SLW+2:0] sl;
    logic [HW+1:0] yy;
    lag = PW'(r_eff) * PW'(w_eff) + PW'(r_eff);
    emit = (out_row < h_eff) && !((in_row < h_eff) && (pending < lag + 1'b1));
    oy_r = {1'b0, out_row} + (HW+1)'(r_eff);
    y0 = (out_row < HW'(r_eff)) ? '0 : (HW+1)'(out_row - HW'(r_eff));
    y1 = (oy_r > (HW+1)'(h_eff - 1'b1)) ? (HW+1)'(h_eff - 1'b1) : oy_r;
    xa = (32'(out_col) < 32'(r_eff)) ? '0 : (WW+1)'(32'(out_col) - 32'(r_eff));
    xb = (WW+1)'(32'(out_col) + 32'(r_eff));
    if (32'(xb) > 32'(w_eff) - 1) xb = (WW+1)'(32'(w_eff) - 1);
    x0_w = CLW'(xa);
    x1_w = CLW'(xb);
    rows_w = RCW'(y1 - y0 + 1'b1);
    cols_w = RCW'(xb - xa + 1'b1);
    mask_w = '0;
    for (int d = 0; d < SPAN; d++) begin
      yy = (HW+2)'(out_row) + (HW+2)'(d);
      sl = (SLW+3)'(out_slot) + (SLW+3)'(RING) - (SLW+3)'(r_eff) + (SLW+3)'(d);
      if (sl >= (SLW+3)'(RING)) sl = sl - (SLW+3)'(RING);
      if (sl >= (SLW+3)'(RING)) sl = sl - (SLW+3)'(RING);
      if ((d <= 2 * int'(r_eff)) && (yy >= (HW+2)'(r_eff)) &&
          (yy <= (HW+2)'(h_eff) - 1'b1 + (HW+2)'(r_eff))) begin
        mask_w[sl[SLW-1:0]] = 1'b1;
      end
    end
  end

  // lanes, one per ring row
  cbmf_pkg::lane_ctl_t    lane_ctl [RING];
  logic signed [LW-1:0]   lane_x [RING];
  logic signed [LW-1:0]   lane_y [RING];
  logic signed [SW-1:0]   sum_x, sum_y;

  for (genvar b = 0; b < RING; b++) begin : g_lane
    assign lane_ctl[b].wr_en = store && (slot_c == SLW'(b));
    assign lane_ctl[b].rd_en = (state == S_SWEEP) && lane_mask[b];
    assign lane_ctl[b].acc_clr = (state == S_CHECK);
    cbmf_lane #(.DEPTH(MAX_WIDTH), .AW(CLW), .LW(LW)) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (lane_ctl[b]),
      .wr_addr (col_c),
      .rd_addr (xx),
      .wr_x    (gx_sample),
      .wr_y    (gy_sample),
      .sum_x   (lane_x[b]),
      .sum_y   (lane_y[b])
    );
  end

  cbmf_merge #(.LANES(RING), .LW(LW), .SW(SW)) u_merge (
    .clk    (clk),
    .en     (state == S_MERGE),
    .lane_x (lane_x),
    .lane_y (lane_y),
    .sum_x  (sum_x),
    .sum_y  (sum_y)
  );

  // rounded magnitude divide, sign applied afterward
  logic [SW-1:0] num_x, num_y, quot_x, quot_y;
  logic          done_x, done_y;

  assign num_x = (sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x)) + SW'(cnt >> 1);
  assign num_y = (sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y)) + SW'(cnt >> 1);

  cbmf_div #(.NW(SW), .DW(CW)) u_div_x (
    .clk (clk), .rst (rst), .start (state == S_DIVGO),
    .num (num_x), .den (cnt), .done (done_x), .quot (quot_x)
  );

  cbmf_div #(.NW(SW), .DW(CW)) u_div_y (
    .clk (clk), .rst (rst), .start (state == S_DIVGO),
    .num (num_y), .den (cnt), .done (done_y), .quot (quot_y)
  );

  logic load_out;
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_CHECK;
      S_CHECK: state_next = emit ? S_SWEEP : S_IDLE;
      S_SWEEP: if (xx == x1) state_next = S_FLUSH;
      S_FLUSH: state_next = S_MERGE;
      S_MERGE: state_next = S_DIVGO;
      S_DIVGO: state_next = S_DIVW;
      S_DIVW:  if (done_x && done_y) state_next = S_DONE;
      S_DONE:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      in_row    <= '0;
      in_col    <= '0;
      in_slot   <= '0;
      out_row   <= '0;
      out_col   <= '0;
      out_slot  <= '0;
      pending   <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        in_row   <= '0;
        in_col   <= '0;
        in_slot  <= '0;
        out_row  <= '0;
        out_col  <= '0;
        out_slot <= '0;
        pending  <= '0;
      end else if (accept) begin
        if (restart) begin
          out_row  <= '0;
          out_col  <= '0;
          out_slot <= '0;
        end
        if (store) begin
          pending <= pend_c + 1'b1;
          if (32'(col_c) + 1 >= 32'(w_eff)) begin
            in_col  <= '0;
            in_row  <= row_c + 1'b1;
            in_slot <= (slot_c == SLW'(RING - 1)) ? '0 : slot_c + 1'b1;
          end else begin
            in_col  <= col_c + 1'b1;
            in_row  <= row_c;
            in_slot <= slot_c;
          end
        end else begin
          in_row  <= row_c;
          in_col  <= col_c;
          in_slot <= slot_c;
          pending <= pend_c;
        end
      end else if (load_out) begin
        pending <= pending - 1'b1;
        if (32'(out_col) + 1 >= 32'(w_eff)) begin
          out_col  <= '0;
          out_row  <= out_row + 1'b1;
          out_slot <= (out_slot == SLW'(RING - 1)) ? '0 : out_slot + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      xx        <= x0_w;
      x1        <= x1_w;
      lane_mask <= mask_w;
      cnt       <= CW'(rows_w) * CW'(cols_w);
      last_pix  <= (out_row == h_eff - 1'b1) && (32'(out_col) == 32'(w_eff) - 1);
    end else if (state == S_SWEEP && xx != x1) begin
      xx <= xx + 1'b1;
    end
    if (load_out) begin
      gx_mean   <= sum_x[SW-1] ? -quot_x[SB-1:0] : quot_x[SB-1:0];
      gy_mean   <= sum_y[SW-1] ? -quot_y[SB-1:0] : quot_y[SB-1:0];
      frame_end <= last_pix;
    end
  end

endmodule
